// File: src/cpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsd_pkg
// Types and constants shared by the column post sprite decoder modules.
// ----------------------------------------------------------------------------
package cpsd_pkg;

    localparam logic [7:0] COLUMN_END = 8'hFF;

    localparam int BYTE_W     = 8;
    localparam int ROW_W      = 9;
    localparam int COLOR_W    = 8;
    localparam int PCOL_W     = 10;
    localparam int ADDR_W     = 19;
    localparam int HCMP_W     = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_H_W    = 10;
    localparam int TDATA_W    = 48;
    localparam int TUSER_W    = 3;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd64;
    localparam logic [CFG_H_W-1:0]    HEIGHT_RESET = 10'd64;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    typedef enum logic [2:0] {
        PH_TOP      = 3'd0,
        PH_LEN      = 3'd1,
        PH_PAD_PRE  = 3'd2,
        PH_DATA     = 3'd3,
        PH_PAD_POST = 3'd4
    } phase_t;

    typedef struct packed {
        logic done;
        logic oob;
    } cmd_ctrl_t;

endpackage
`default_nettype wire

// File: src/cpsd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsd_front
// Column post parser: walks the post phases and emits pixel and done commands.
// ----------------------------------------------------------------------------
module cpsd_front #(
    parameter int CW = 10,
    parameter int WW = 11,
    parameter int HW = 10
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    byte_accept,
    input  wire logic [7:0]              data_byte,
    input  wire logic [WW-1:0]           width,
    input  wire logic [HW-1:0]           height,
    output logic                         push,
    output cpsd_pkg::cmd_ctrl_t          cmd_ctrl,
    output logic [CW-1:0]                cmd_col,
    output logic [cpsd_pkg::ROW_W-1:0]   cmd_row,
    output logic [cpsd_pkg::COLOR_W-1:0] cmd_color
);
    import cpsd_pkg::*;

    localparam int CMPW = WW + 1;

    phase_t              phase_reg, phase_next;
    logic [CW-1:0]       column_reg, column_next;
    logic [7:0]          top_row_reg, top_row_next;
    logic [7:0]          bytes_left_reg, bytes_left_next;
    logic [7:0]          row_in_post_reg, row_in_post_next;

    logic                last_column;
    logic [ROW_W-1:0]    row_now;
    logic                col_oob;
    logic                row_oob;

    assign last_column = (CMPW'(column_reg) + CMPW'(1)) >= CMPW'(width);
    assign row_now     = {1'b0, top_row_reg} + {1'b0, row_in_post_reg};
    assign col_oob     = CMPW'(column_reg) >= CMPW'(width);
    assign row_oob     = HCMP_W'(row_now) >= HCMP_W'(height);

    always_comb
    begin
        phase_next       = phase_reg;
        column_next      = column_reg;
        top_row_next     = top_row_reg;
        bytes_left_next  = bytes_left_reg;
        row_in_post_next = row_in_post_reg;
        if (byte_accept)
        begin
            case (phase_reg)
                PH_TOP:
                begin
                    if (data_byte == COLUMN_END)
                    begin
                        if (last_column)
                            column_next = '0;
                        else
                            column_next = column_reg + CW'(1);
                    end
                    else
                    begin
                        top_row_next = data_byte;
                        phase_next   = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    bytes_left_next  = data_byte;
                    row_in_post_next = '0;
                    phase_next       = PH_PAD_PRE;
                end
                PH_PAD_PRE:
                begin
                    phase_next = (bytes_left_reg == 8'd0) ? PH_PAD_POST : PH_DATA;
                end
                PH_DATA:
                begin
                    bytes_left_next  = bytes_left_reg - 8'd1;
                    row_in_post_next = row_in_post_reg + 8'd1;
                    if (bytes_left_reg == 8'd1)
                        phase_next = PH_PAD_POST;
                end
                PH_PAD_POST:
                begin
                    phase_next = PH_TOP;
                end
                default:
                begin
                    phase_next = PH_TOP;
                end
            endcase
        end
    end

    always_comb
    begin
        push          = 1'b0;
        cmd_ctrl.done = 1'b0;
        cmd_ctrl.oob  = 1'b0;
        cmd_col       = '0;
        cmd_row       = '0;
        cmd_color     = '0;
        case (phase_reg)
            PH_TOP:
            begin
                push          = byte_accept && (data_byte == COLUMN_END) && last_column;
                cmd_ctrl.done = 1'b1;
            end
            PH_DATA:
            begin
                push         = byte_accept;
                cmd_ctrl.oob = col_oob || row_oob;
                cmd_col      = column_reg;
                cmd_row      = row_now;
                cmd_color    = data_byte;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TOP;
            column_reg      <= '0;
            top_row_reg     <= '0;
            bytes_left_reg  <= '0;
            row_in_post_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            column_reg      <= column_next;
            top_row_reg     <= top_row_next;
            bytes_left_reg  <= bytes_left_next;
            row_in_post_reg <= row_in_post_next;
        end
    end

endmodule
`default_nettype wire

// File: src/cpsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsd_queue
// Short command queue between the parser and the address stage.
// ----------------------------------------------------------------------------
module cpsd_queue #(
    parameter int DW = 30
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output logic [DW-1:0]      head_data
);
    import cpsd_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign full       = count_reg == NW'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: src/cpsd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsd_back
// Address pipeline: row times width, add column, register the output word.
// ----------------------------------------------------------------------------
module cpsd_back #(
    parameter int CW = 10,
    parameter int WW = 11
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [WW-1:0]                   width,
    input  wire logic                            head_valid,
    input  wire cpsd_pkg::cmd_ctrl_t             head_ctrl,
    input  wire logic [CW-1:0]                   head_col,
    input  wire logic [cpsd_pkg::ROW_W-1:0]      head_row,
    input  wire logic [cpsd_pkg::COLOR_W-1:0]    head_color,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [cpsd_pkg::TDATA_W-1:0]         m_tdata,
    output logic [cpsd_pkg::TUSER_W-1:0]         m_tuser
);
    import cpsd_pkg::*;

    localparam int PRW = ROW_W + WW;
    localparam int PAD = TDATA_W - ADDR_W - COLOR_W - ROW_W - PCOL_W;

    logic               a_valid_reg, a_valid_next;
    cmd_ctrl_t          a_ctrl_reg;
    logic [CW-1:0]      a_col_reg;
    logic [ROW_W-1:0]   a_row_reg;
    logic [COLOR_W-1:0] a_color_reg;
    logic [PRW-1:0]     a_prod_reg;

    logic               m_valid_reg, m_valid_next;
    logic [TDATA_W-1:0] m_data_reg;
    logic [TUSER_W-1:0] m_user_reg;

    logic               out_load;
    logic               a_load;
    logic [PRW:0]       addr_sum;
    logic [ADDR_W-1:0]  addr;

    assign out_load = a_valid_reg && (!m_valid_reg || m_tready);
    assign a_load   = head_valid && (!a_valid_reg || out_load);
    assign pop      = a_load;

    assign addr_sum = (PRW + 1)'(a_prod_reg) + (PRW + 1)'(a_col_reg);
    assign addr     = (a_ctrl_reg.oob || a_ctrl_reg.done) ? '0 : ADDR_W'(addr_sum);

    always_comb
    begin
        if (a_load)
            a_valid_next = 1'b1;
        else if (out_load)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;

        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_ctrl_reg  <= head_ctrl;
            a_col_reg   <= head_col;
            a_row_reg   <= head_row;
            a_color_reg <= head_color;
            a_prod_reg  <= PRW'(head_row) * PRW'(width);
        end
        if (out_load)
        begin
            m_data_reg <= {{PAD{1'b0}}, addr, a_color_reg, a_row_reg, PCOL_W'(a_col_reg)};
            m_user_reg <= {a_ctrl_reg.done, a_ctrl_reg.oob,
                           !(a_ctrl_reg.oob || a_ctrl_reg.done)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
`default_nettype wire

// File: src/column_post_sprite_decoder_top.sv
// A byte that causes a result goes through the command queue and the address pipeline.
// Throughput: one byte per cycle while m_tready keeps up; the four-word command queue and the
// two-stage address pipeline (row times width, then add column) set that figure.
// Reset: rst_n clears the parser to expect a top-row byte at column zero, empties the
// queue and the pipeline, and sets image_width and image_height to 64.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// column_post_sprite_decoder_top
// Column post sprite decoder: bytes in, pixel writes and done words out.
// ----------------------------------------------------------------------------
module column_post_sprite_decoder_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // [7:0] data_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [9:0] pixel_column, [18:10] pixel_row, [26:19] color_index,
    // [45:27] pixel_address, [47:46] zero
    output logic [cpsd_pkg::TDATA_W-1:0]            m_tdata,
    // [0] pixel_valid, [1] out_of_bounds, [2] picture_done
    output logic [cpsd_pkg::TUSER_W-1:0]            m_tuser,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cpsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cpsd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cpsd_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int QW = 2 + CW + ROW_W + COLOR_W;

    logic [CFG_DATA_W-1:0] width_cfg_reg, width_cfg_next;
    logic [CFG_H_W-1:0]    height_cfg_reg, height_cfg_next;
    logic [WW-1:0]         width;
    logic [HW-1:0]         height;

    logic                  byte_accept;
    logic                  push;
    cmd_ctrl_t             cmd_ctrl;
    logic [CW-1:0]         cmd_col;
    logic [ROW_W-1:0]      cmd_row;
    logic [COLOR_W-1:0]    cmd_color;
    logic                  q_full;
    logic                  pop;
    logic                  head_valid;
    logic [QW-1:0]         head_data;
    cmd_ctrl_t             head_ctrl;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_cfg_next  = width_cfg_reg;
        height_cfg_next = height_cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_cfg_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_cfg_next = cfg_data[CFG_H_W-1:0];
                default:          width_cfg_next  = width_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_cfg_reg  <= width_cfg_next;
            height_cfg_reg <= height_cfg_next;
        end
    end

    always_comb
    begin
        if (width_cfg_reg == '0)
            width = WW'(1);
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
            width = WW'(MAX_WIDTH);
        else
            width = WW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            height = HW'(1);
        else if (32'(height_cfg_reg) > 32'(MAX_HEIGHT))
            height = HW'(MAX_HEIGHT);
        else
            height = HW'(height_cfg_reg);
    end

    assign s_tready    = !q_full;
    assign byte_accept = s_tvalid && s_tready;

    cpsd_front #(
        .CW (CW),
        .WW (WW),
        .HW (HW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .data_byte   (s_tdata),
        .width       (width),
        .height      (height),
        .push        (push),
        .cmd_ctrl    (cmd_ctrl),
        .cmd_col     (cmd_col),
        .cmd_row     (cmd_row),
        .cmd_color   (cmd_color)
    );

    cpsd_queue #(
        .DW (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({cmd_ctrl, cmd_col, cmd_row, cmd_color}),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    assign head_ctrl = head_data[QW-1 -: 2];

    cpsd_back #(
        .CW (CW),
        .WW (WW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .width      (width),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_col   (head_data[ROW_W+COLOR_W +: CW]),
        .head_row   (head_data[COLOR_W +: ROW_W]),
        .head_color (head_data[COLOR_W-1:0]),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
`default_nettype wire

// File: src/cpsd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpsd_checker
// Port-level checks of the result words of the sprite decoder.
// ----------------------------------------------------------------------------
module cpsd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // exactly one of pixel write, out-of-bounds pixel, done
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(m_tuser))
        else $error("result word carries more or less than one kind");

    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> (m_tdata == 48'd0))
        else $error("done word carries nonzero payload");

    a_oob_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[45:27] == 19'd0))
        else $error("suppressed pixel carries an address");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind column_post_sprite_decoder_top cpsd_checker u_cpsd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the column post sprite decoder. A byte queue feeds
// a clocked stream driver; every accepted byte steps a behavioral decoder
// that queues the pixel or done word it should produce, and a clocked monitor
// compares each output word field by field. Sprites are built from random
// posts over several size settings and idle mixes, including a long output
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
    import cpsd_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 512;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hFF;

    typedef struct packed {
        logic        pv;
        logic        oob;
        logic        done;
        logic [9:0]  col;
        logic [8:0]  row;
        logic [7:0]  color;
        logic [18:0] addr;
    } pixel_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [TUSER_W-1:0]    m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [7:0]  byte_q [$];
    pixel_word_t pix_q [$];
    pixel_word_t want;
    int          queued_bytes = 0;
    int          accepted_bytes = 0;
    int          mismatches = 0;
    int          s_idle_pct = 0;
    int          m_idle_pct = 0;
    bit          hold_go = 1'b0;
    bit          hold_used = 1'b0;
    int          hold_left = 0;

    // behavioral decoder state
    logic [CFG_DATA_W-1:0] cfg_width = WIDTH_RESET;
    logic [CFG_H_W-1:0]    cfg_height = HEIGHT_RESET;
    phase_t                post_state = PH_TOP;
    logic [9:0]            col_cnt = '0;
    logic [7:0]            top_row = '0;
    logic [7:0]            left = '0;
    logic [7:0]            row_off = '0;

    column_post_sprite_decoder_top #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int clamp_to(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output pixel_word_t pw);
        int w;
        int h;
        int row;
        bit hit;
        w = clamp_to(cfg_width, MAX_W);
        h = clamp_to(cfg_height, MAX_H);
        pw = '0;
        hit = 1'b0;
        case (post_state)
            PH_TOP:
            begin
                if (b == COLUMN_END)
                begin
                    if (col_cnt + 1 >= w)
                    begin
                        col_cnt = '0;
                        pw.done = 1'b1;
                        hit = 1'b1;
                    end
                    else
                        col_cnt = col_cnt + 1'b1;
                end
                else
                begin
                    top_row = b;
                    post_state = PH_LEN;
                end
            end
            PH_LEN:
            begin
                left = b;
                row_off = '0;
                post_state = PH_PAD_PRE;
            end
            PH_PAD_PRE:
                post_state = (left == 0) ? PH_PAD_POST : PH_DATA;
            PH_DATA:
            begin
                row = top_row + row_off;
                pw.oob = (col_cnt >= w) || (row >= h);
                pw.pv = !pw.oob;
                pw.col = col_cnt;
                pw.row = row[8:0];
                pw.color = b;
                pw.addr = pw.oob ? '0 : 19'(row * w + col_cnt);
                left = left - 1'b1;
                row_off = row_off + 1'b1;
                if (left == 0)
                    post_state = PH_PAD_POST;
                hit = 1'b1;
            end
            PH_PAD_POST:
                post_state = PH_TOP;
            default:
                post_state = PH_TOP;
        endcase
        return hit;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v, input int unsigned got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // stream driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || s_tready)
        begin
            if (byte_q.size() != 0 && $urandom_range(0, 99) >= s_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= byte_q.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    always @(posedge clk)
    begin
        pixel_word_t pw;
        if (rst_n && s_tvalid && s_tready)
        begin
            accepted_bytes++;
            if (decode_byte(s_tdata, pw))
                pix_q.push_back(pw);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pix_q.size() == 0)
            begin
                $error("word with none pending: tdata=%h tuser=%h", m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = pix_q.pop_front();
                check_field("pixel_valid", want.pv, m_tuser[0]);
                check_field("out_of_bounds", want.oob, m_tuser[1]);
                check_field("picture_done", want.done, m_tuser[2]);
                check_field("pixel_column", want.col, m_tdata[9:0]);
                check_field("pixel_row", want.row, m_tdata[18:10]);
                check_field("color_index", want.color, m_tdata[26:19]);
                check_field("pixel_address", want.addr, m_tdata[45:27]);
            end
        end
    end

    function automatic void put_byte(input logic [7:0] b);
        byte_q.push_back(b);
        queued_bytes++;
    endfunction

    function automatic void put_post(input int top, input int len);
        put_byte(8'(top));
        put_byte(8'(len));
        put_byte(8'($urandom_range(0, 255)));
        repeat (len) put_byte(8'($urandom_range(0, 255)));
        put_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_sprite(input int ncols, input int nrows);
        int nposts;
        int top;
        int len;
        int r;
        int top_hi;
        top_hi = (nrows > 255) ? 254 : nrows - 1;
        for (int c = 0; c < ncols; c++)
        begin
            nposts = (ncols > 64) ? int'($urandom_range(0, 127) == 0) : $urandom_range(0, 3);
            for (int p = 0; p < nposts; p++)
            begin
                r = $urandom_range(0, 9);
                top = (r < 6) ? $urandom_range(0, top_hi) : (r < 9) ? $urandom_range(0, 254) : 254;
                r = $urandom_range(0, 19);
                len = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 255) : $urandom_range(1, 6);
                put_post(top, len);
            end
            if (ncols == MAX_W && c == ncols - 1)
                put_post(254, 255);
            put_byte(COLUMN_END);
        end
    endfunction

    task automatic settle();
        while (accepted_bytes != queued_bytes || pix_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_size(input logic [10:0] w, input logic [9:0] h, input bit poke);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = REG_SPARE;
        val[0] = 11'h7FF;
        idx[1] = REG_IMAGE_WIDTH;
        val[1] = w;
        idx[2] = REG_IMAGE_HEIGHT;
        val[2] = {1'b0, h};
        for (int i = poke ? 0 : 1; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do @(posedge clk); while (!cfg_ready);
            if (idx[i] == REG_IMAGE_WIDTH)
                cfg_width = val[i];
            else if (idx[i] == REG_IMAGE_HEIGHT)
                cfg_height = val[i][CFG_H_W-1:0];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int s_pct, input int m_pct, input logic [10:0] w,
                             input logic [9:0] h, input bit poke, input int budget);
        int start;
        int ncols;
        int nrows;
        settle();
        program_size(w, h, poke);
        s_idle_pct <= s_pct;
        m_idle_pct <= m_pct;
        ncols = clamp_to(w, MAX_W);
        nrows = clamp_to(h, MAX_H);
        start = queued_bytes;
        while (queued_bytes - start < budget)
        begin
            queue_sprite(ncols, nrows);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        logic [7:0] first_sprite [18];
        logic [7:0] tail_post [6];
        first_sprite = '{8'h00, 8'h02, 8'hFF, 8'h00, 8'hFF, 8'h00,
                         8'h02, 8'h02, 8'hAA, 8'h55, 8'hAA, 8'h55, COLUMN_END,
                         8'hFE, 8'h00, 8'h00, 8'h00, COLUMN_END};
        tail_post = '{8'h01, 8'h01, 8'h00, 8'h3C, 8'h00, COLUMN_END};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        program_size(11'd2, 10'd3, 1'b0);
        foreach (first_sprite[i])
            put_byte(first_sprite[i]);
        settle();
        program_size(11'd4, 10'd3, 1'b0);
        put_byte(COLUMN_END);
        put_byte(COLUMN_END);
        // shrink the width with the column counter already past it
        settle();
        program_size(11'd2, 10'd3, 1'b0);
        foreach (tail_post[i])
            put_byte(tail_post[i]);

        run_phase(0, 0, 11'd3, 10'd16, 1'b0, 60);
        run_phase(45, 0, 11'd0, 10'd0, 1'b0, 40);
        settle();
        hold_go <= 1'b1;
        run_phase(0, 45, 11'd6, 10'd1023, 1'b0, 1);
        run_phase(32, 32, 11'd2047, 10'd512, 1'b0, 1);
        run_phase(32, 32, 11'($urandom_range(3, 8)), 10'($urandom_range(20, 300)), 1'b1, 1);
        settle();

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #400us;
        $display("== FAIL ==");
        $finish;
    end

endmodule
